@@ rtl/fara_pkg.sv @@
`default_nettype none

package fara_pkg;

	localparam int DATA_W    = 32;
	localparam int DIV_STEPS = DATA_W;
	localparam int CNT_W     = $clog2(DIV_STEPS);

	typedef enum logic [3:0] {
		OP_NOP  = 4'd0,
		OP_LOAD = 4'd1,
		OP_MOVE = 4'd2,
		OP_ADD  = 4'd3,
		OP_SUB  = 4'd4,
		OP_MUL  = 4'd5,
		OP_DIV  = 4'd6,
		OP_AND  = 4'd7,
		OP_OR   = 4'd8,
		OP_XOR  = 4'd9,
		OP_NOT  = 4'd10
	} op_t;

	typedef enum logic [1:0] {
		ERR_OK      = 2'd0,
		ERR_INDEX   = 2'd1,
		ERR_DIVZERO = 2'd2,
		ERR_OPCODE  = 2'd3
	} err_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FETCH,
		ST_EXEC,
		ST_DIV,
		ST_WRITE,
		ST_DONE
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic load_in;
		logic fetch;
		logic exec;
		logic div_start;
		logic div_step;
		logic write;
		logic publish;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		err_t err;
		logic is_nop;
		logic is_div;
		logic div_last;
		logic out_free;
	} status_t;

	localparam logic [7:0] CHAR_ZERO = 8'h30;
	localparam logic [7:0] CHAR_NINE = 8'h39;
	localparam logic [7:0] CHAR_A    = 8'h41;
	localparam int         HEX_TEN   = 10;

	// hex digit to value; letters use c - 'A' + 10, wrapping for anything else
	function automatic logic [DATA_W-1:0] hex_value(input logic [7:0] ch);
		logic [DATA_W-1:0] wide;
		wide = {{(DATA_W-8){1'b0}}, ch};
		if (ch >= CHAR_ZERO && ch <= CHAR_NINE)
			return wide - {{(DATA_W-8){1'b0}}, CHAR_ZERO};
		else
			return wide - {{(DATA_W-8){1'b0}}, CHAR_A} + DATA_W'(HEX_TEN);
	endfunction

endpackage

`default_nettype wire

@@ rtl/fara_ctrl.sv @@
`default_nettype none

module fara_ctrl (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    in_valid,
	output logic                   in_stall,
	input  wire fara_pkg::status_t status,
	output fara_pkg::cmd_t         cmd
);

	fara_pkg::state_t state_q, state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fara_pkg::ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			fara_pkg::ST_IDLE: begin
				if (in_valid)
					state_next = fara_pkg::ST_FETCH;
			end
			fara_pkg::ST_FETCH: state_next = fara_pkg::ST_EXEC;
			fara_pkg::ST_EXEC: begin
				if (status.err != fara_pkg::ERR_OK || status.is_nop)
					state_next = fara_pkg::ST_DONE;
				else if (status.is_div)
					state_next = fara_pkg::ST_DIV;
				else
					state_next = fara_pkg::ST_WRITE;
			end
			fara_pkg::ST_DIV: begin
				if (status.div_last)
					state_next = fara_pkg::ST_WRITE;
			end
			fara_pkg::ST_WRITE: state_next = fara_pkg::ST_DONE;
			fara_pkg::ST_DONE: begin
				if (status.out_free)
					state_next = fara_pkg::ST_IDLE;
			end
			default: state_next = fara_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			fara_pkg::ST_IDLE: begin
				in_stall    = 1'b0;
				cmd.load_in = in_valid;
			end
			fara_pkg::ST_FETCH: cmd.fetch = 1'b1;
			fara_pkg::ST_EXEC: begin
				cmd.exec      = 1'b1;
				cmd.div_start = status.is_div && status.err == fara_pkg::ERR_OK;
			end
			fara_pkg::ST_DIV:   cmd.div_step = 1'b1;
			fara_pkg::ST_WRITE: cmd.write = 1'b1;
			fara_pkg::ST_DONE:  cmd.publish = status.out_free;
			default: ;
		endcase
	end

`ifndef NO_ASSERTIONS
	a_div_exit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == fara_pkg::ST_DIV && !status.div_last) |=> state_q == fara_pkg::ST_DIV)
		else $error("divide left early");
	a_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == fara_pkg::ST_DONE && !status.out_free) |=> state_q == fara_pkg::ST_DONE)
		else $error("result dropped while output busy");
	a_write_src: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == fara_pkg::ST_WRITE |-> ($past(state_q) == fara_pkg::ST_EXEC ||
			$past(state_q) == fara_pkg::ST_DIV))
		else $error("write without execute");
`endif

endmodule

`default_nettype wire

@@ rtl/fara_dp.sv @@
`default_nettype none

module fara_dp #(
	parameter int REG_COUNT = 4
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire fara_pkg::cmd_t cmd,
	output fara_pkg::status_t   status,
	input  wire  [3:0]        operation,
	input  wire  [3:0]        dest_index,
	input  wire  [3:0]        source_index,
	input  wire  [7:0]        immediate_char,
	input  wire               out_stall,
	output logic              out_valid,
	output logic signed [31:0] reg_zero,
	output logic signed [31:0] reg_one,
	output logic signed [31:0] reg_two,
	output logic signed [31:0] reg_three,
	output logic [1:0]        error_code
);

	localparam int IW = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
	localparam int DW = fara_pkg::DATA_W;

	logic [DW-1:0] rf_q [REG_COUNT];

	fara_pkg::op_t    op_q;
	logic [3:0]       di_q, si_q;
	logic [7:0]       ch_q;
	logic [DW-1:0]    a_q, b_q, res_q;
	fara_pkg::err_t   err_q, err_c;
	logic             di_ok, si_ok;

	// divider
	logic [DW-1:0]             rem_q, quo_q, dvs_q;
	logic                      neg_q;
	logic [fara_pkg::CNT_W-1:0] cnt_q;
	logic [DW:0]               shifted;
	logic [DW+1:0]             diff;
	logic [DW-1:0]             quo_fix, wdata;

	logic                      out_valid_q;
	logic [DW-1:0]             out_q [4];
	logic [1:0]                out_err_q;

	assign di_ok = {1'b0, di_q} < 5'(REG_COUNT);
	assign si_ok = {1'b0, si_q} < 5'(REG_COUNT);

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			op_q <= fara_pkg::op_t'(operation);
			di_q <= dest_index;
			si_q <= source_index;
			ch_q <= immediate_char;
		end
		if (cmd.fetch) begin
			a_q <= di_ok ? rf_q[di_q[IW-1:0]] : '0;
			b_q <= si_ok ? rf_q[si_q[IW-1:0]] : '0;
		end
	end

	always_comb begin
		err_c = fara_pkg::ERR_OK;
		unique case (op_q) inside
			fara_pkg::OP_NOP: err_c = fara_pkg::ERR_OK;
			fara_pkg::OP_LOAD: begin
				if (!di_ok)
					err_c = fara_pkg::ERR_INDEX;
			end
			fara_pkg::OP_MOVE, fara_pkg::OP_ADD, fara_pkg::OP_SUB, fara_pkg::OP_MUL,
			fara_pkg::OP_AND, fara_pkg::OP_OR, fara_pkg::OP_XOR, fara_pkg::OP_NOT: begin
				if (!di_ok || !si_ok)
					err_c = fara_pkg::ERR_INDEX;
			end
			fara_pkg::OP_DIV: begin
				if (!di_ok || !si_ok)
					err_c = fara_pkg::ERR_INDEX;
				else if (b_q == '0)
					err_c = fara_pkg::ERR_DIVZERO;
			end
			default: err_c = fara_pkg::ERR_OPCODE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			err_q <= err_c;
			case (op_q)
				fara_pkg::OP_LOAD: res_q <= fara_pkg::hex_value(ch_q);
				fara_pkg::OP_MOVE: res_q <= b_q;
				fara_pkg::OP_ADD:  res_q <= a_q + b_q;
				fara_pkg::OP_SUB:  res_q <= a_q - b_q;
				fara_pkg::OP_MUL:  res_q <= a_q * b_q;
				fara_pkg::OP_AND:  res_q <= a_q & b_q;
				fara_pkg::OP_OR:   res_q <= a_q | b_q;
				fara_pkg::OP_XOR:  res_q <= a_q ^ b_q;
				fara_pkg::OP_NOT:  res_q <= ~b_q;
				default:           res_q <= a_q;
			endcase
		end
	end

	// restoring division on magnitudes, one quotient bit per cycle
	assign shifted = {rem_q, quo_q[DW-1]};
	assign diff    = {1'b0, shifted} - {2'b00, dvs_q};

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			rem_q <= '0;
			quo_q <= a_q[DW-1] ? -a_q : a_q;
			dvs_q <= b_q[DW-1] ? -b_q : b_q;
			neg_q <= a_q[DW-1] ^ b_q[DW-1];
		end else if (cmd.div_step) begin
			if (!diff[DW+1]) begin
				rem_q <= diff[DW-1:0];
				quo_q <= {quo_q[DW-2:0], 1'b1};
			end else begin
				rem_q <= shifted[DW-1:0];
				quo_q <= {quo_q[DW-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.div_start) begin
			cnt_q <= '0;
		end else if (cmd.div_step) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	assign quo_fix = neg_q ? -quo_q : quo_q;
	assign wdata   = (op_q == fara_pkg::OP_DIV) ? quo_fix : res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < REG_COUNT; i++)
				rf_q[i] <= '0;
		end else if (cmd.write) begin
			rf_q[di_q[IW-1:0]] <= wdata;
		end
	end

	// output register; a new transaction may be taken while this one waits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.publish) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	for (genvar k = 0; k < 4; k++) begin : g_out
		if (k < REG_COUNT) begin : g_live
			always_ff @(posedge clk) begin
				if (cmd.publish)
					out_q[k] <= rf_q[k];
			end
		end else begin : g_zero
			always_ff @(posedge clk) begin
				if (cmd.publish)
					out_q[k] <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.publish)
			out_err_q <= err_q;
	end

	assign out_valid  = out_valid_q;
	assign reg_zero   = out_q[0];
	assign reg_one    = out_q[1];
	assign reg_two    = out_q[2];
	assign reg_three  = out_q[3];
	assign error_code = out_err_q;

	assign status.err      = err_c;
	assign status.is_nop   = op_q == fara_pkg::OP_NOP;
	assign status.is_div   = op_q == fara_pkg::OP_DIV;
	assign status.div_last = cnt_q == fara_pkg::CNT_W'(fara_pkg::DIV_STEPS - 1);
	assign status.out_free = !out_valid_q || !out_stall;

`ifndef NO_ASSERTIONS
	a_write_ok: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.write |-> err_q == fara_pkg::ERR_OK)
		else $error("register write on an errored instruction");
	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |-> b_q != '0)
		else $error("divider started with zero divisor");
	a_pub_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.publish |-> (!out_valid_q || !out_stall))
		else $error("result overwritten while stalled");
`endif

endmodule

`default_nettype wire

@@ rtl/four_register_alu_machine.sv @@
`default_nettype none

// Channel | Handshake          | Payload
// input   | in_valid/in_stall   | operation, dest_index, source_index, immediate_char
// output  | out_valid/out_stall | reg_zero, reg_one, reg_two, reg_three, error_code
//
// One instruction at a time. Most opcodes pass the fetch, execute, write and done
// states between accepts; nop and errored instructions skip the write state. Divide
// adds the divide state; the restoring divider makes one quotient bit per cycle.
// Reset clears the register file and the controller; the block is ready at once.
// A stalled result sits in the output register while the next instruction runs;
// that one is held in the controller until the output register frees up.

module four_register_alu_machine #(
	parameter int REG_COUNT = 4
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               in_valid,
	output logic              in_stall,
	input  wire  [3:0]        operation,
	input  wire  [3:0]        dest_index,
	input  wire  [3:0]        source_index,
	input  wire  [7:0]        immediate_char,
	output logic              out_valid,
	input  wire               out_stall,
	output logic signed [31:0] reg_zero,
	output logic signed [31:0] reg_one,
	output logic signed [31:0] reg_two,
	output logic signed [31:0] reg_three,
	output logic [1:0]        error_code
);

	fara_pkg::cmd_t    cmd;
	fara_pkg::status_t status;

	fara_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	fara_dp #(
		.REG_COUNT (REG_COUNT)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.status         (status),
		.operation      (operation),
		.dest_index     (dest_index),
		.source_index   (source_index),
		.immediate_char (immediate_char),
		.out_stall      (out_stall),
		.out_valid      (out_valid),
		.reg_zero       (reg_zero),
		.reg_one        (reg_one),
		.reg_two        (reg_two),
		.reg_three      (reg_three),
		.error_code     (error_code)
	);

endmodule

`default_nettype wire

@@ verif/tb_four_register_alu_machine.sv @@
`default_nettype none

module tb_four_register_alu_machine;

	localparam int REGS        = 4;
	localparam int RAND_ITEMS  = 1000;
	localparam int TAIL_ITEMS  = 150;   // no idling once this few items are left
	localparam int HOLD_AFTER  = 300;   // accepted instructions before the long hold-off
	localparam int HOLD_CYCLES = 400;
	localparam int DRAIN_CYCLES = 60;

	localparam logic [3:0] REG0 = 4'd0;
	localparam logic [3:0] REG1 = 4'd1;
	localparam logic [3:0] REG2 = 4'd2;
	localparam logic [3:0] REG3 = 4'd3;
	localparam logic [3:0] IDX_BAD_MIN = 4'd4;
	localparam logic [3:0] IDX_BAD_MAX = 4'd15;
	localparam logic [3:0] OP_UNDEF_LO = 4'd11;
	localparam logic [3:0] OP_UNDEF_HI = 4'd15;

	typedef struct packed {
		logic [3:0] op;
		logic [3:0] dst;
		logic [3:0] src;
		logic [7:0] ch;
	} instr_t;

	typedef struct packed {
		logic [3:0][31:0] regs;
		fara_pkg::err_t   err;
	} machine_state_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic [3:0] operation = '0;
	logic [3:0] dest_index = '0;
	logic [3:0] source_index = '0;
	logic [7:0] immediate_char = '0;
	logic out_stall = 1'b0;
	wire in_stall;
	wire out_valid;
	wire signed [31:0] reg_zero, reg_one, reg_two, reg_three;
	wire [1:0] error_code;

	four_register_alu_machine dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.operation(operation),
		.dest_index(dest_index),
		.source_index(source_index),
		.immediate_char(immediate_char),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.reg_zero(reg_zero),
		.reg_one(reg_one),
		.reg_two(reg_two),
		.reg_three(reg_three),
		.error_code(error_code)
	);

	instr_t pend_instrs [$];
	machine_state_t expected_states [$];
	logic [3:0][31:0] arch_regs = '0;

	logic in_took = 1'b0;
	logic hold_off = 1'b0;
	int in_gap = 0;
	int out_gap = 0;
	int instr_count = 0;
	int fail_count = 0;
	int result_count = 0;
	int div_tally = 0;
	int err_tally [4] = '{0, 0, 0, 0};
	string reg_names [4] = '{"reg_zero", "reg_one", "reg_two", "reg_three"};
	instr_t drv_instr;
	machine_state_t want;
	logic [3:0][31:0] got_regs;

	always #5 clk = ~clk;

	// architectural effect of one instruction; updates arch_regs
	function automatic machine_state_t execute_instr(input instr_t ins);
		machine_state_t res;
		logic [31:0] d, s, r, nmag, dmag, qmag;
		res.err = fara_pkg::ERR_OK;
		case (ins.op) inside
			fara_pkg::OP_NOP: ;
			fara_pkg::OP_LOAD: begin
				if (ins.dst >= REGS)
					res.err = fara_pkg::ERR_INDEX;
				else if (ins.ch >= fara_pkg::CHAR_ZERO && ins.ch <= fara_pkg::CHAR_NINE)
					arch_regs[ins.dst] = {24'd0, ins.ch} - {24'd0, fara_pkg::CHAR_ZERO};
				else
					arch_regs[ins.dst] = {24'd0, ins.ch} - {24'd0, fara_pkg::CHAR_A}
						+ 32'(fara_pkg::HEX_TEN);
			end
			fara_pkg::OP_MOVE, fara_pkg::OP_ADD, fara_pkg::OP_SUB, fara_pkg::OP_MUL,
			fara_pkg::OP_DIV, fara_pkg::OP_AND, fara_pkg::OP_OR, fara_pkg::OP_XOR,
			fara_pkg::OP_NOT: begin
				if (ins.dst >= REGS || ins.src >= REGS) begin
					res.err = fara_pkg::ERR_INDEX;
				end else begin
					d = arch_regs[ins.dst];
					s = arch_regs[ins.src];
					r = d;
					case (ins.op)
						fara_pkg::OP_MOVE: r = s;
						fara_pkg::OP_ADD:  r = d + s;
						fara_pkg::OP_SUB:  r = d - s;
						fara_pkg::OP_MUL:  r = d * s;
						fara_pkg::OP_DIV: begin
							if (s == 32'd0) begin
								res.err = fara_pkg::ERR_DIVZERO;
							end else begin
								// magnitudes, then sign; -2^31 / -1 wraps back to -2^31
								nmag = d[31] ? 32'd0 - d : d;
								dmag = s[31] ? 32'd0 - s : s;
								qmag = nmag / dmag;
								r = (d[31] ^ s[31]) ? 32'd0 - qmag : qmag;
							end
						end
						fara_pkg::OP_AND:  r = d & s;
						fara_pkg::OP_OR:   r = d | s;
						fara_pkg::OP_XOR:  r = d ^ s;
						fara_pkg::OP_NOT:  r = ~s;
						default: ;
					endcase
					arch_regs[ins.dst] = r;
				end
			end
			default: res.err = fara_pkg::ERR_OPCODE;
		endcase
		res.regs = arch_regs;
		return res;
	endfunction

	function automatic logic [3:0] rand_index();
		if ($urandom_range(0, 11) == 0)
			return 4'($urandom_range(IDX_BAD_MIN, IDX_BAD_MAX));
		return 4'($urandom_range(0, REGS - 1));
	endfunction

	task automatic queue_instr(input logic [3:0] op, input logic [3:0] dst,
			input logic [3:0] src, input logic [7:0] ch);
		pend_instrs.push_back('{op: op, dst: dst, src: src, ch: ch});
	endtask

	// driver: inputs move on the falling edge
	always @(negedge clk) begin
		if (arst_n && (!in_valid || in_took)) begin
			if (in_gap != 0) begin
				in_gap <= in_gap - 1;
				in_valid <= 1'b0;
			end else if (pend_instrs.size() == 0) begin
				in_valid <= 1'b0;
			end else if (pend_instrs.size() > TAIL_ITEMS && $urandom_range(0, 4) == 0) begin
				in_gap <= $urandom_range(0, 2);
				in_valid <= 1'b0;
			end else begin
				drv_instr = pend_instrs.pop_front();
				in_valid <= 1'b1;
				operation <= drv_instr.op;
				dest_index <= drv_instr.dst;
				source_index <= drv_instr.src;
				immediate_char <= drv_instr.ch;
			end
		end
	end

	// result side stalls
	always @(negedge clk) begin
		if (out_gap != 0) begin
			out_gap <= out_gap - 1;
			out_stall <= 1'b1;
		end else if (pend_instrs.size() > TAIL_ITEMS && $urandom_range(0, 4) == 0) begin
			out_gap <= $urandom_range(0, 2);
			out_stall <= 1'b1;
		end else begin
			out_stall <= hold_off;
		end
	end

	// monitor: both channels sampled on the rising edge
	always @(posedge clk) begin
		in_took <= arst_n && in_valid && !in_stall;
		if (arst_n && out_valid && !out_stall) begin
			result_count <= result_count + 1;
			if (expected_states.size() == 0) begin
				$display("%0t: result transaction with nothing expected", $time);
				fail_count = fail_count + 1;
			end else begin
				want = expected_states.pop_front();
				got_regs = {reg_three, reg_two, reg_one, reg_zero};
				err_tally[want.err] <= err_tally[want.err] + 1;
				for (int k = 0; k < 4; k++) begin
					if (got_regs[k] !== want.regs[k]) begin
						$display("%0t: %s expected %h actual %h", $time, reg_names[k],
							want.regs[k], got_regs[k]);
						fail_count = fail_count + 1;
					end
				end
				if (error_code !== want.err) begin
					$display("%0t: error_code expected %0d actual %0d", $time, want.err,
						error_code);
					fail_count = fail_count + 1;
				end
			end
		end
		if (arst_n && in_valid && !in_stall) begin
			expected_states.push_back(execute_instr({operation, dest_index, source_index,
				immediate_char}));
			instr_count <= instr_count + 1;
			if (operation == fara_pkg::OP_DIV)
				div_tally <= div_tally + 1;
		end
	end

	// long output hold-off so the block backs up into its input
	initial begin
		while (instr_count < HOLD_AFTER)
			@(posedge clk);
		@(negedge clk);
		hold_off <= 1'b1;
		repeat (HOLD_CYCLES) @(negedge clk);
		hold_off <= 1'b0;
	end

	initial begin
		#3000000;
		$display("timeout: %0d instructions pending, %0d results outstanding",
			pend_instrs.size(), expected_states.size());
		$display("simulation failed");
		$finish;
	end

	initial begin
		logic [3:0] op;
		logic [7:0] ch;

		queue_instr(fara_pkg::OP_NOP, IDX_BAD_MAX, IDX_BAD_MAX, 8'hFF);
		queue_instr(fara_pkg::OP_LOAD, REG0, REG0, fara_pkg::CHAR_ZERO + 8'd8);
		queue_instr(fara_pkg::OP_LOAD, REG1, REG0, fara_pkg::CHAR_A + 8'd6);   // 'G' -> 16
		repeat (7) queue_instr(fara_pkg::OP_MUL, REG0, REG1, 8'h00); // 8 * 16^7 = 2^31
		queue_instr(fara_pkg::OP_LOAD, REG2, REG0, fara_pkg::CHAR_ZERO);
		queue_instr(fara_pkg::OP_NOT, REG3, REG2, 8'h00);            // -1
		queue_instr(fara_pkg::OP_DIV, REG0, REG3, 8'h00);            // most negative / -1
		queue_instr(fara_pkg::OP_DIV, REG1, REG2, 8'h00);            // zero divisor
		queue_instr(fara_pkg::OP_LOAD, IDX_BAD_MIN, REG0, fara_pkg::CHAR_A);
		queue_instr(fara_pkg::OP_LOAD, REG2, IDX_BAD_MAX, 8'h00);   // below '7', wraps negative
		queue_instr(fara_pkg::OP_DIV, REG0, REG2, 8'h00);
		queue_instr(fara_pkg::OP_ADD, REG1, REG3, 8'h00);
		queue_instr(fara_pkg::OP_SUB, REG2, REG0, 8'h00);
		queue_instr(fara_pkg::OP_MOVE, REG3, REG0, 8'h00);
		queue_instr(fara_pkg::OP_AND, REG1, REG2, 8'h00);
		queue_instr(fara_pkg::OP_OR, REG2, REG3, 8'h00);
		queue_instr(fara_pkg::OP_XOR, REG3, REG1, 8'h00);
		queue_instr(fara_pkg::OP_ADD, REG0, IDX_BAD_MIN, 8'h00);
		queue_instr(fara_pkg::OP_SUB, IDX_BAD_MAX, REG0, 8'h00);
		queue_instr(OP_UNDEF_LO, REG0, REG1, 8'h00);
		queue_instr(OP_UNDEF_HI, IDX_BAD_MAX, IDX_BAD_MAX, 8'h00);

		for (int n = 0; n < RAND_ITEMS; n++) begin
			if ($urandom_range(0, 19) == 0)
				op = 4'($urandom_range(OP_UNDEF_LO, OP_UNDEF_HI));
			else
				op = 4'($urandom_range(fara_pkg::OP_NOP, fara_pkg::OP_NOT));
			case ($urandom_range(0, 2))
				0: ch = fara_pkg::CHAR_ZERO + 8'($urandom_range(0, 9));
				1: ch = fara_pkg::CHAR_A + 8'($urandom_range(0, 5));
				default: ch = 8'($urandom_range(0, 255));
			endcase
			queue_instr(op, rand_index(), rand_index(), ch);
		end

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (pend_instrs.size() != 0 || in_valid || expected_states.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		if (expected_states.size() != 0) begin
			$display("%0t: %0d results expected but never seen", $time,
				expected_states.size());
			fail_count = fail_count + 1;
		end

		$display("%0d instructions, %0d results checked, %0d divides, %0d-cycle output hold-off",
			instr_count, result_count, div_tally, HOLD_CYCLES);
		$display("errors seen: %0d none, %0d bad index, %0d divide by zero, %0d bad opcode",
			err_tally[fara_pkg::ERR_OK], err_tally[fara_pkg::ERR_INDEX],
			err_tally[fara_pkg::ERR_DIVZERO], err_tally[fara_pkg::ERR_OPCODE]);
		if (fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

`default_nettype wire

@@ filelist.f @@
rtl/fara_pkg.sv
rtl/fara_ctrl.sv
rtl/fara_dp.sv
rtl/four_register_alu_machine.sv
verif/tb_four_register_alu_machine.sv
